FILE: src/dot_star_pattern_matcher_core_assert.svh
// Assertion macros of the dot-star matcher RTL, used by dsp_engine.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef DOT_STAR_PATTERN_MATCHER_CORE_ASSERT_SVH
`define DOT_STAR_PATTERN_MATCHER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define DSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define DSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/dsp_pkg.sv
// Shared types and constants of the dot-star pattern matcher.
// No dependencies.
package dsp_pkg;

  localparam int MAX_TOKENS = 32;
  localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
  localparam int IDX_W      = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int POS_W      = MAX_TOKENS + 1;
  localparam int SYM_W      = 8;

  localparam logic [SYM_W-1:0] SYM_ANY  = 8'h2E;
  localparam logic [SYM_W-1:0] SYM_STAR = 8'h2A;

  typedef enum logic [1:0] {
    KIND_PAT_BYTE  = 2'd0,
    KIND_PAT_END   = 2'd1,
    KIND_TEXT_BYTE = 2'd2,
    KIND_TEXT_END  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [SYM_W-1:0]  symbol;
  } item_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } res_t;

endpackage

FILE: src/dsp_ifs.sv
// Valid/ready channel interfaces for the matcher's item input and result output.
// Depends on dsp_pkg.
interface dsp_in_if;
  logic                     valid;
  logic                     ready;
  dsp_pkg::kind_t           kind;
  logic [dsp_pkg::SYM_W-1:0] symbol;

  modport source (output valid, output kind, output symbol, input ready);
  modport sink   (input valid, input kind, input symbol, output ready);
endinterface

interface dsp_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic overflow;

  modport source (output valid, output matched, output overflow, input ready);
  modport sink   (input valid, input matched, input overflow, output ready);
endinterface

FILE: src/dsp_in_stage.sv
// Input register of the matcher: holds one accepted transaction for the engine.
// Depends on dsp_pkg and dsp_in_if.
module dsp_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  dsp_in_if.sink          in_ch,
  output logic            item_vld,
  output dsp_pkg::item_t  item,
  input  logic            item_take
);

  logic           vld_r;
  dsp_pkg::item_t item_r;

  // Take a new transaction when empty or when the held one leaves this cycle
  assign in_ch.ready = !vld_r || item_take;
  assign item_vld    = vld_r;
  assign item        = item_r;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      vld_r <= 1'b1;
    end else if (item_take) begin
      vld_r <= 1'b0;
    end
  end

  // Load the payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.kind   <= in_ch.kind;
      item_r.symbol <= in_ch.symbol;
    end
  end

endmodule

FILE: src/dsp_engine.sv
// Token store and bit-vector NFA of the matcher; one item per cycle while a text end finds room for its result.
// Depends on dsp_pkg and dot_star_pattern_matcher_core_assert.svh.
`include "dot_star_pattern_matcher_core_assert.svh"

module dsp_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_vld,
  input  dsp_pkg::item_t  item,
  output logic            item_take,
  input  logic            res_room,
  output logic            res_vld,
  output dsp_pkg::res_t   res
);

  // Token store: byte and star bit per entry, no reset
  logic [dsp_pkg::SYM_W-1:0] sym_mem_r [dsp_pkg::MAX_TOKENS];
  logic [dsp_pkg::MAX_TOKENS-1:0] star_r;

  logic [dsp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [dsp_pkg::POS_W-1:0] active_r, active_nxt;
  logic [dsp_pkg::POS_W-1:0] start_r, start_nxt;
  logic [dsp_pkg::POS_W-1:0] live_r, live_nxt;   // start set of the store as it stands
  logic                      loading_r, loading_nxt;
  logic                      too_long_r, too_long_nxt;
  logic                      last_star_r, last_star_nxt;

  logic [dsp_pkg::MAX_TOKENS-1:0] tok_vld;
  logic [dsp_pkg::CNT_W-1:0]      cnt_eff, cnt_m1;
  logic [dsp_pkg::POS_W-1:0]      live_eff, act_eff, start_eff;
  logic                           tl_eff, last_star_eff;
  logic                           star_ext, wr_append, wr_star;
  logic [dsp_pkg::POS_W-1:0]      step, clo;
  logic                           hit;
  logic                           is_text_end;

  assign is_text_end = (item.kind == dsp_pkg::KIND_TEXT_END);
  assign item_take   = item_vld && (!is_text_end || res_room);
  assign res_vld     = item_take && is_text_end;

  // Tokens in use
  always_comb begin
    for (int i = 0; i < dsp_pkg::MAX_TOKENS; i++) begin
      tok_vld[i] = (dsp_pkg::CNT_W'(i) < cnt_r);
    end
  end

  // A pattern byte after a finished pattern starts a fresh store
  assign cnt_eff       = loading_r ? cnt_r : '0;
  assign tl_eff        = loading_r ? too_long_r : 1'b0;
  assign last_star_eff = loading_r ? last_star_r : 1'b0;
  assign live_eff      = loading_r ? live_r : dsp_pkg::POS_W'(1);
  assign cnt_m1        = cnt_eff - dsp_pkg::CNT_W'(1);
  assign star_ext      = (item.symbol == dsp_pkg::SYM_STAR) && (cnt_eff != '0) &&
                         !last_star_eff;

  // Close the pattern implicitly when text arrives during loading
  assign act_eff   = loading_r ? live_r : active_r;
  assign start_eff = loading_r ? live_r : start_r;

  // NFA step on a text byte, then ripple closure over starred tokens
  always_comb begin
    step = '0;
    for (int i = 0; i < dsp_pkg::MAX_TOKENS; i++) begin
      hit = tok_vld[i] && act_eff[i] &&
            ((sym_mem_r[i] == dsp_pkg::SYM_ANY) || (sym_mem_r[i] == item.symbol));
      step[i]   = step[i]   | (hit && star_r[i]);
      step[i+1] = step[i+1] | (hit && !star_r[i]);
    end
    clo[0] = step[0];
    for (int i = 0; i < dsp_pkg::MAX_TOKENS; i++) begin
      clo[i+1] = step[i+1] | (clo[i] && star_r[i] && tok_vld[i]);
    end
  end

  // Next state per item kind
  always_comb begin
    cnt_nxt       = cnt_r;
    active_nxt    = active_r;
    start_nxt     = start_r;
    live_nxt      = live_r;
    loading_nxt   = loading_r;
    too_long_nxt  = too_long_r;
    last_star_nxt = last_star_r;
    wr_append     = 1'b0;
    wr_star       = 1'b0;
    res.matched   = act_eff[cnt_r] && !too_long_r;
    res.overflow  = too_long_r;
    if (item_take) begin
      case (item.kind)
        dsp_pkg::KIND_PAT_BYTE: begin
          loading_nxt   = 1'b1;
          cnt_nxt       = cnt_eff;
          too_long_nxt  = tl_eff;
          live_nxt      = live_eff;
          last_star_nxt = last_star_eff;
          if (!tl_eff) begin
            if (star_ext) begin
              wr_star           = 1'b1;
              last_star_nxt     = 1'b1;
              live_nxt[cnt_eff] = live_eff[cnt_m1];
            end else if (cnt_eff < dsp_pkg::CNT_W'(dsp_pkg::MAX_TOKENS)) begin
              wr_append     = 1'b1;
              last_star_nxt = 1'b0;
              cnt_nxt       = cnt_eff + dsp_pkg::CNT_W'(1);
            end else begin
              too_long_nxt = 1'b1;
            end
          end
        end
        dsp_pkg::KIND_PAT_END: begin
          loading_nxt   = 1'b0;
          cnt_nxt       = cnt_eff;
          too_long_nxt  = tl_eff;
          live_nxt      = live_eff;
          last_star_nxt = last_star_eff;
          start_nxt     = live_eff;
          active_nxt    = live_eff;
        end
        dsp_pkg::KIND_TEXT_BYTE: begin
          loading_nxt = 1'b0;
          start_nxt   = start_eff;
          active_nxt  = clo;
        end
        dsp_pkg::KIND_TEXT_END: begin
          loading_nxt = 1'b0;
          start_nxt   = start_eff;
          active_nxt  = start_eff;
        end
        default: begin
          loading_nxt = loading_r;
        end
      endcase
    end
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      active_r    <= '0;
      start_r     <= '0;
      live_r      <= dsp_pkg::POS_W'(1);
      loading_r   <= 1'b0;
      too_long_r  <= 1'b0;
      last_star_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      active_r    <= active_nxt;
      start_r     <= start_nxt;
      live_r      <= live_nxt;
      loading_r   <= loading_nxt;
      too_long_r  <= too_long_nxt;
      last_star_r <= last_star_nxt;
    end
  end

  // Write the token store
  always_ff @(posedge clk) begin
    if (wr_append) begin
      sym_mem_r[cnt_eff[dsp_pkg::IDX_W-1:0]] <= item.symbol;
      star_r[cnt_eff[dsp_pkg::IDX_W-1:0]]    <= 1'b0;
    end else if (wr_star) begin
      star_r[cnt_m1[dsp_pkg::IDX_W-1:0]] <= 1'b1;
    end
  end

  `DSP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= dsp_pkg::CNT_W'(dsp_pkg::MAX_TOKENS), "token count past store size")
  `DSP_ASSERT_NOW(a_overflow_full, too_long_r, cnt_r == dsp_pkg::CNT_W'(dsp_pkg::MAX_TOKENS), "overflow with store not full")
  `DSP_ASSERT_NOW(a_live_origin, loading_r, live_r[0], "start set lost its origin position")
  `DSP_ASSERT_NOW(a_match_no_ovf, res_vld && res.matched, !res.overflow, "match reported on overflowed pattern")
  `DSP_ASSERT_NEXT(a_rearm, res_vld, active_r == start_r, "NFA not re-armed after text end")

endmodule

FILE: src/dsp_out_stage.sv
// Result register of the matcher: holds one result transaction until taken.
// Depends on dsp_pkg and dsp_out_if.
module dsp_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_vld,
  input  dsp_pkg::res_t  res,
  output logic           res_room,
  dsp_out_if.source      out_ch
);

  logic          vld_r;
  dsp_pkg::res_t res_r;

  // Free when empty or when the held result leaves this cycle
  assign res_room        = !vld_r || out_ch.ready;
  assign out_ch.valid    = vld_r;
  assign out_ch.matched  = res_r.matched;
  assign out_ch.overflow = res_r.overflow;

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res_vld) begin
      vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      vld_r <= 1'b0;
    end
  end

  // Load the result
  always_ff @(posedge clk) begin
    if (res_vld) begin
      res_r <= res;
    end
  end

endmodule

FILE: src/dot_star_pattern_matcher_core.sv
// Top level of the dot-star pattern matcher.
// Depends on dsp_pkg, dsp_ifs, dsp_in_stage, dsp_engine and dsp_out_stage.
//
// Usage:
//   in_ch carries items of four kinds: pattern byte, pattern end, text byte
//   and text end. A pattern is sent byte by byte ('.' any byte, 'x*' zero or
//   more x), then texts are sent byte by byte, each closed by a text end.
//   out_ch carries one result per text end: matched, and overflow when the
//   pattern needed more than dsp_pkg::MAX_TOKENS tokens (matched is then 0).
//   Throughput: one item per cycle, a text end only when the result
//   register has room; the NFA step and its star closure process each item
//   between the input register and the result register; the latter drives
//   out_ch.valid with the result of each text end.
//   Stall: the result register holds while out_ch.ready is low; a further
//   text end then waits in the input register and in_ch.ready drops, while
//   pattern and text bytes ahead of it keep flowing.
//   Reset (rst_n low, synchronous) empties both registers, clears the pattern
//   and leaves no pattern loaded, so text ends report no match until a
//   pattern has been ended.
module dot_star_pattern_matcher_core (
  input  logic       clk,
  input  logic       rst_n,
  dsp_in_if.sink     in_ch,
  dsp_out_if.source  out_ch
);

  logic           item_vld;
  dsp_pkg::item_t item;
  logic           item_take;
  logic           res_room;
  logic           res_vld;
  dsp_pkg::res_t  res;

  dsp_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .item_vld  (item_vld),
    .item      (item),
    .item_take (item_take)
  );

  dsp_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (item_vld),
    .item      (item),
    .item_take (item_take),
    .res_room  (res_room),
    .res_vld   (res_vld),
    .res       (res)
  );

  dsp_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_vld  (res_vld),
    .res      (res),
    .res_room (res_room),
    .out_ch   (out_ch)
  );

endmodule
